@@ rtl/mmbl_pkg.sv @@
// ---------------------------------------------------------------------------
// mmbl_pkg
// Types and constants shared by the multicart menu bank latch.
// ---------------------------------------------------------------------------
package mmbl_pkg;

    // Menu command bytes
    localparam logic [7:0] CMD_ROM_BANK = 8'hAA;
    localparam logic [7:0] CMD_RAM_BANK = 8'hBB;
    localparam logic [7:0] CMD_MODE     = 8'h55;

    // Address regions, by top nibble
    localparam logic [3:0] REGION_CMD = 4'h5;
    localparam logic [3:0] REGION_ACT = 4'h7;
    // 0x2000-0x3FFF, top three bits
    localparam logic [2:0] REGION_BANK_SEL = 3'b001;
    // 0x20-0x3F window for the RAM select, top three bits
    localparam logic [2:0] RAM_SEL_WINDOW = 3'b001;

    // Mode byte bits
    localparam int MODE_BIT_RESET = 7;
    localparam int MODE_BIT_ROM_HI = 3;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_PAD_W  = 6;

    // Input item; address sits in the low bits of tdata
    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] address;
    } in_item_t;

    // Result item; forward_valid sits in bit 0 of tdata
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic                 reset_request;
        logic                 map_changed;
        logic                 locked;
        logic                 mbc1_mode_on;
        logic [2:0]           rom_size_code;
        logic [17:0]          ram_offset;
        logic [23:0]          rom_offset;
        logic [7:0]           forward_data;
        logic [15:0]          forward_address;
        logic                 forward_valid;
    } result_t;

endpackage

@@ rtl/mmbl_in_reg.sv @@
// ---------------------------------------------------------------------------
// mmbl_in_reg
// Input register: holds one CPU write until the decode stage takes it.
// ---------------------------------------------------------------------------
module mmbl_in_reg
    import mmbl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     advance,
    output logic     held_valid,
    output in_item_t held_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Free slot, or the held item leaves this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

@@ rtl/mmbl_engine.sv @@
// ---------------------------------------------------------------------------
// mmbl_engine
// Menu state and write decode: latches commands, performs the switch and
// builds the result of the held write. State moves on advance; config can load the size code.
// ---------------------------------------------------------------------------
module mmbl_engine
    import mmbl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  logic       advance,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_wr_data,
    output result_t    res
);

    logic [7:0]  cmd_reg,      cmd_next;
    logic [7:0]  rom_sel_reg,  rom_sel_next;
    logic [7:0]  ram_sel_reg,  ram_sel_next;
    logic [7:0]  mode_reg,     mode_next;
    logic        lock_reg,     lock_next;
    logic        mbc1_reg,     mbc1_next;
    logic [23:0] rom_base_reg, rom_base_next;
    logic [17:0] ram_base_reg, ram_base_next;
    logic [2:0]  size_reg,     size_next;
    logic        switched_reg, switched_next;

    logic        fwd;
    logic        changed;
    logic        want_reset;
    logic [15:0] fwd_addr;
    logic [7:0]  fwd_data;

    // Decode the held write and compute the state after it
    always_comb
    begin
        cmd_next      = cmd_reg;
        rom_sel_next  = rom_sel_reg;
        ram_sel_next  = ram_sel_reg;
        mode_next     = mode_reg;
        lock_next     = lock_reg;
        mbc1_next     = mbc1_reg;
        rom_base_next = rom_base_reg;
        ram_base_next = ram_base_reg;
        size_next     = size_reg;
        switched_next = switched_reg;
        fwd           = 1'b1;
        changed       = 1'b0;
        want_reset    = 1'b0;

        if (!lock_reg)
        begin
            if (item.address[15:12] == REGION_CMD)
            begin
                cmd_next = item.data;
                fwd      = 1'b0;
            end
            else if (item.address[15:12] == REGION_ACT)
            begin
                fwd = 1'b0;
                if (cmd_reg == CMD_ROM_BANK)
                begin
                    // no bank yet: latch it; bank already chosen: switch now, stay unlocked
                    if (rom_sel_reg == 8'h00)
                        rom_sel_next = item.data;
                    else
                        changed = 1'b1;
                end
                else if (cmd_reg == CMD_RAM_BANK)
                begin
                    ram_sel_next = item.data;
                end
                else if (cmd_reg == CMD_MODE)
                begin
                    mode_next = item.data;
                    changed   = 1'b1;
                    lock_next = 1'b1;
                end
            end
        end

        // Switch: new offsets and flags, latches cleared
        if (changed)
        begin
            want_reset    = mode_next[MODE_BIT_RESET];
            mbc1_next     = mode_next[6] && mode_next[5];
            size_next     = ~mode_next[2:0];
            rom_base_next = {mode_next[MODE_BIT_ROM_HI], rom_sel_reg, 15'd0};
            if (ram_sel_reg[7:5] == RAM_SEL_WINDOW)
                ram_base_next = {ram_sel_reg[4:0], 13'd0};
            else
                ram_base_next = 18'd0;
            switched_next = 1'b1;
            cmd_next      = 8'h00;
            rom_sel_next  = 8'h00;
            ram_sel_next  = 8'h00;
            mode_next     = 8'h00;
        end
    end

    // Forward path with MBC1-style fold of the bank register range
    always_comb
    begin
        fwd_addr = item.address;
        fwd_data = item.data;
        if (mbc1_next && item.address[15:13] == REGION_BANK_SEL)
        begin
            fwd_addr[12] = 1'b0;
            if (item.data == 8'h00)
                fwd_data = 8'h01;
        end
    end

    always_comb
    begin
        res                 = '0;
        res.forward_valid   = fwd;
        res.forward_address = fwd ? fwd_addr : 16'h0000;
        res.forward_data    = fwd ? fwd_data : 8'h00;
        res.rom_offset      = rom_base_next;
        res.ram_offset      = ram_base_next;
        res.rom_size_code   = size_next;
        res.mbc1_mode_on    = mbc1_next;
        res.locked          = lock_next;
        res.map_changed     = changed;
        res.reset_request   = want_reset;
    end

    // State registers; config only loads the size code before a switch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= 8'h00;
            rom_sel_reg  <= 8'h00;
            ram_sel_reg  <= 8'h00;
            mode_reg     <= 8'h00;
            lock_reg     <= 1'b0;
            mbc1_reg     <= 1'b0;
            rom_base_reg <= 24'd0;
            ram_base_reg <= 18'd0;
            size_reg     <= 3'd0;
            switched_reg <= 1'b0;
        end
        else if (advance)
        begin
            cmd_reg      <= cmd_next;
            rom_sel_reg  <= rom_sel_next;
            ram_sel_reg  <= ram_sel_next;
            mode_reg     <= mode_next;
            lock_reg     <= lock_next;
            mbc1_reg     <= mbc1_next;
            rom_base_reg <= rom_base_next;
            ram_base_reg <= ram_base_next;
            size_reg     <= size_next;
            switched_reg <= switched_next;
        end
        else if (cfg_wr_en && !switched_reg)
        begin
            size_reg <= cfg_wr_data;
        end
    end

`ifndef SYNTHESIS
    // lock is sticky
    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(lock_reg))
        else $error("menu lock released");

    // locking always goes through a switch
    a_lock_switched: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg |-> switched_reg)
        else $error("locked without a switch");
`endif

endmodule

@@ rtl/multicart_menu_bank_latch.sv @@
// ---------------------------------------------------------------------------
// multicart_menu_bank_latch
// Multicart menu latch: consumes menu writes, switches ROM/RAM base and
// mode on command, forwards other writes to the bank mapper.
//
// Channel   Dir  Bits  Contents (low bit up)
// s_axis    in   24    address[15:0], data[23:16]
// m_axis    out  80    forward_valid, forward_address, forward_data,
//                      rom_offset, ram_offset, rom_size_code, mbc1_mode_on,
//                      locked, map_changed, reset_request, zero pad
// cfg       in   3     initial_rom_size, written on cfg_wr_en before any switch
//
// One write per cycle while m_axis is not stalled; the result passes the
// input register, the decode and the result register.
// Reset clears all menu state; the size code reads 0 until configured.
// A stalled result holds the output; the input register still takes one
// more write, then s_axis_tready drops until the result is taken.
// ---------------------------------------------------------------------------
module multicart_menu_bank_latch
    import mmbl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // address[15:0], data[23:16]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // forward_valid[0], forward_address[16:1], forward_data[24:17],
    // rom_offset[48:25], ram_offset[66:49], rom_size_code[69:67],
    // mbc1_mode_on[70], locked[71], map_changed[72], reset_request[73]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_wr_data
);

    logic     held_valid;
    in_item_t held_item;
    logic     advance;
    result_t  res;
    result_t  out_reg;
    logic     out_valid_reg;
    logic     out_valid_next;

    // Held write moves on when the result slot is free or draining
    assign advance = held_valid && (!out_valid_reg || m_axis_tready);

    mmbl_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item_t'(s_axis_tdata)),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    mmbl_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (held_item),
        .advance     (advance),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (res)
    );

    // Result register
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

`ifndef SYNTHESIS
    // a switching write is consumed, never forwarded
    a_switch_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.map_changed) |-> !out_reg.forward_valid)
        else $error("switch write forwarded");

    // reset request only comes with a switch
    a_reset_with_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.reset_request) |-> out_reg.map_changed)
        else $error("reset request without switch");

    // input backpressure only when both stages are full and output stalls
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (held_valid && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without cause");
`endif

endmodule
